[hdl/fe2_pkg.sv]
package fe2_pkg;

  localparam int TableBitsDef = 10;
  localparam int SumW = 56;
  localparam int FracQ = 48;

  typedef enum logic [1:0] {
    CLS_NORMAL,
    CLS_NAN,
    CLS_ZERO,
    CLS_INF
  } cls_t;

  typedef struct packed {
    logic vld;
    cls_t cls;
  } fe2_ctl_t;

  localparam logic [31:0] QnanBits = 32'h7FC0_0000;
  localparam logic [31:0] InfBits  = 32'h7F80_0000;
  localparam logic [31:0] NegLimit = 32'h4180_0000;
  localparam logic [31:0] PosLimit = 32'h4300_0000;
  localparam logic [7:0]  ExpBias  = 8'd110;

  // Reciprocal of a small positive integer by Newton iteration, starting from
  // the power of two at or just above it.
  function automatic real recip_of(int n);
    real g;
    real r;
    g = 1.0;
    r = 1.0;
    while (g < real'(n)) begin
      g = g * 2.0;
      r = r * 0.5;
    end
    for (int i = 0; i < 7; i++) begin
      r = r * (2.0 - real'(n) * r);
    end
    return r;
  endfunction

  // Stored mantissa of 2^(k/depth), series evaluation rounded to nearest-even.
  function automatic logic [22:0] mant_entry(int k, int tbits);
    real x;
    real t;
    real term;
    real sum;
    real m;
    real r;
    real step;
    int  tr;
    step = 1.0;
    for (int i = 0; i < tbits; i++) begin
      step = step * 0.5;
    end
    x = real'(k) * step;
    t = x * 0.69314718055994530942;
    term = 1.0;
    sum = 1.0;
    for (int n = 1; n < 30; n++) begin
      term = term * t * recip_of(n);
      sum = sum + term;
    end
    m = sum * 8388608.0;
    tr = $rtoi(m);
    r = m - real'(tr);
    if (r > 0.5 || (r == 0.5 && tr[0])) begin
      tr = tr + 1;
    end
    return tr[22:0];
  endfunction

endpackage

[hdl/fe2_align.sv]
module fe2_align (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [31:0]             x_bits,
  output fe2_pkg::fe2_ctl_t       ctl,
  output logic [fe2_pkg::SumW-1:0] sum
);
  import fe2_pkg::*;

  logic       sign;
  logic [7:0] expf;
  logic [22:0] frac;
  cls_t       cls_next;
  logic [SumW-1:0] mag_next;
  logic [5:0] shamt;

  fe2_ctl_t   ctl1;
  logic       sign1;
  logic [SumW-1:0] mag;

  assign sign = x_bits[31];
  assign expf = x_bits[30:23];
  assign frac = x_bits[22:0];
  assign shamt = 6'(expf - 8'd102);

  always_comb begin
    if (expf == 8'hFF && frac != '0) begin
      cls_next = CLS_NAN;
    end else if (sign && {1'b0, x_bits[30:0]} > NegLimit) begin
      cls_next = CLS_ZERO;
    end else if (!sign && x_bits >= PosLimit) begin
      cls_next = CLS_INF;
    end else begin
      cls_next = CLS_NORMAL;
    end
    if (expf >= 8'd107 && cls_next == CLS_NORMAL) begin
      mag_next = SumW'({1'b1, frac}) << shamt;
    end else begin
      mag_next = '0;
    end
  end

  // Stage one: classification and alignment of the significand.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1.vld <= 1'b0;
    end else begin
      ctl1.vld <= start;
    end
    ctl1.cls <= cls_next;
    sign1 <= sign;
    mag <= mag_next;
  end

  // Stage two: the offset of seventeen is added or subtracted.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.vld <= 1'b0;
    end else begin
      ctl.vld <= ctl1.vld;
    end
    ctl.cls <= ctl1.cls;
    if (sign1) begin
      sum <= (SumW'(17) << FracQ) - mag;
    end else begin
      sum <= (SumW'(17) << FracQ) + mag;
    end
  end

endmodule

[hdl/fe2_round.sv]
module fe2_round #(
  parameter int TABLE_BITS = fe2_pkg::TableBitsDef
) (
  input  logic                     clk,
  input  logic                     rst,
  input  fe2_pkg::fe2_ctl_t        ctl_in,
  input  logic [fe2_pkg::SumW-1:0] sum,
  output fe2_pkg::fe2_ctl_t        ctl,
  output logic [7:0]               ipart,
  output logic [TABLE_BITS-1:0]    idx
);
  import fe2_pkg::*;

  logic [5:0] drop_next;
  fe2_ctl_t   ctl3;
  logic [SumW-1:0] sum3;
  logic [5:0] drop;

  logic [SumW-1:0] shr;
  logic [24:0] rnd;
  logic        rbit;
  logic        sticky;
  logic [SumW:0] back;

  // The sum always lies between 1 and 145, so its top one is in bits 55 to 48.
  always_comb begin
    drop_next = 6'd25;
    for (int i = 0; i < 8; i++) begin
      if (sum[FracQ + i]) begin
        drop_next = 6'(25 + i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl3.vld <= 1'b0;
    end else begin
      ctl3.vld <= ctl_in.vld;
    end
    ctl3.cls <= ctl_in.cls;
    sum3 <= sum;
    drop <= drop_next;
  end

  always_comb begin
    shr = sum3 >> drop;
    rbit = sum3[drop - 6'd1];
    sticky = |(sum3 & ((SumW'(1) << (drop - 6'd1)) - SumW'(1)));
    rnd = {1'b0, shr[23:0]} + 25'(rbit && (sticky || shr[0]));
    back = (SumW+1)'(rnd) << drop;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.vld <= 1'b0;
    end else begin
      ctl.vld <= ctl3.vld;
    end
    ctl.cls <= ctl3.cls;
    ipart <= back[FracQ+7:FracQ];
    idx <= back[FracQ-1:FracQ-TABLE_BITS];
  end

endmodule

[hdl/fe2_lookup.sv]
module fe2_lookup #(
  parameter int TABLE_BITS = fe2_pkg::TableBitsDef
) (
  input  logic                  clk,
  input  logic                  rst,
  input  fe2_pkg::fe2_ctl_t     ctl,
  input  logic [7:0]            ipart,
  input  logic [TABLE_BITS-1:0] idx,
  output logic                  done,
  output logic [31:0]           y_bits,
  output logic                  overflow
);
  import fe2_pkg::*;

  localparam int Depth = 1 << TABLE_BITS;

  typedef logic [22:0] rom_arr_t [Depth];

  function automatic rom_arr_t build_rom();
    rom_arr_t a;
    for (int k = 0; k < Depth; k++) begin
      a[k] = mant_entry(k, TABLE_BITS);
    end
    return a;
  endfunction

  localparam rom_arr_t Rom = build_rom();

  logic [31:0] y_next;

  always_comb begin
    case (ctl.cls)
      CLS_NAN:  y_next = QnanBits;
      CLS_ZERO: y_next = '0;
      CLS_INF:  y_next = InfBits;
      default:  y_next = {1'b0, ipart + ExpBias, Rom[idx]};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.vld;
    end
    y_bits <= y_next;
    overflow <= (ctl.cls == CLS_INF);
  end

endmodule

[hdl/fast_float_exp2_top.sv]
// Table-based 2^x in single precision. One item may be started in every
// clock cycle; busy is always low. Each result appears on y_bits and
// overflow marked by done for one cycle; the receiver cannot stall, so it
// must take every result as it comes. Each item passes through five
// register stages in order: classification and alignment, the add of
// seventeen, the leading-one search, rounding to single precision, and the
// mantissa table read. Inputs below -16 give +0, inputs of 128 and above
// give +infinity with overflow raised, and any NaN gives the quiet NaN. The
// mantissa table is a constant built at elaboration and needs no clearing
// after reset.
module fast_float_exp2_top #(
  parameter int TABLE_BITS = fe2_pkg::TableBitsDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] x_bits,
  output logic        busy,
  output logic        done,
  output logic [31:0] y_bits,
  output logic        overflow
);
  import fe2_pkg::*;

  fe2_ctl_t              ctl_a;
  fe2_ctl_t              ctl_r;
  logic [SumW-1:0]       sum;
  logic [7:0]            ipart;
  logic [TABLE_BITS-1:0] idx;

  // The pipeline never holds off, so a new item is always welcome.
  assign busy = 1'b0;

  fe2_align u_align (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .x_bits (x_bits),
    .ctl    (ctl_a),
    .sum    (sum)
  );

  fe2_round #(.TABLE_BITS(TABLE_BITS)) u_round (
    .clk    (clk),
    .rst    (rst),
    .ctl_in (ctl_a),
    .sum    (sum),
    .ctl    (ctl_r),
    .ipart  (ipart),
    .idx    (idx)
  );

  fe2_lookup #(.TABLE_BITS(TABLE_BITS)) u_lookup (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl_r),
    .ipart    (ipart),
    .idx      (idx),
    .done     (done),
    .y_bits   (y_bits),
    .overflow (overflow)
  );

endmodule
